// File: rtl/jpdva_pkg.sv
// shared constants, item types and helpers for the joint pd controller
// with moving-average velocity; no dependencies
package jpdva_pkg;

    // structure sizes
    localparam int JOINTS       = 7;
    localparam int FILTER_DEPTH = 8;
    localparam int QUEUE_DEPTH  = 2;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int JOINT_W   = 3;
    localparam int FL_W      = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;

    // derived widths
    localparam int SLOTS     = JOINTS * FILTER_DEPTH;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W     = $clog2(FILTER_DEPTH + 1);
    localparam int RING_W    = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int SUM_W     = DATA_W + $clog2(FILTER_DEPTH);
    localparam int SUM_CNT_W = $clog2(SUM_W + 1);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TOT_W     = PROD_W + 2;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_LENGTH = CFG_IDX_W'(2);

    // register reset values
    localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 32'd13107200;
    localparam logic [DATA_W-1:0] DERIV_GAIN_RST = 32'd655360;
    localparam logic [FL_W-1:0]   FL_RST         = 4'd5;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint_index;
        logic signed [DATA_W-1:0] desired_position;
        logic signed [DATA_W-1:0] measured_position;
        logic signed [DATA_W-1:0] measured_velocity;
    } in_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint_out;
        logic signed [DATA_W-1:0] torque;
        logic                     saturated;
    } out_item_t;

    // divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [LEN_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quot_mag;
        logic             quot_neg;
    } div_rsp_t;

    // filter length as used: zero reads as one, clamp at the history depth
    function automatic logic [LEN_W-1:0] eff_len(input logic [FL_W-1:0] fl);
        logic [LEN_W-1:0] res;
        if (fl == '0)
            res = LEN_W'(1);
        else if (int'(fl) > FILTER_DEPTH)
            res = LEN_W'(FILTER_DEPTH);
        else
            res = LEN_W'(fl);
        return res;
    endfunction

endpackage

// File: rtl/jpdva_front.sv
// front end: accepts input items and drops those for joints that do not exist
// depends on jpdva_pkg
module jpdva_front
    import jpdva_pkg::*;
(
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     q_push,
    output in_item_t q_push_data
);

    logic joint_ok;

    // classify by joint number
    assign joint_ok = int'(in_data.joint_index) < JOINTS;

    // hold the source off while the queue has no room
    assign in_stall    = q_full;
    assign q_push      = in_valid && !q_full && joint_ok;
    assign q_push_data = in_data;

endmodule

// File: rtl/jpdva_fifo.sv
// short item queue between front end and back end
// depends on jpdva_pkg
module jpdva_fifo
    import jpdva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t push_data,
    output logic     full,
    input  logic     pop,
    output in_item_t pop_data,
    output logic     empty
);

    in_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                do_push, do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/jpdva_div.sv
// bit-serial signed divider of a history sum by the filter length,
// quotient rounded toward zero; depends on jpdva_pkg
module jpdva_div
    import jpdva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [SUM_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     work_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     divisor_reg;
    logic [SUM_W-1:0]     dividend_mag;
    logic [LEN_W:0]       trial;
    logic [LEN_W:0]       diff;
    logic                 ge;
    logic [LEN_W-1:0]     rem_next;
    logic [SUM_W-1:0]     work_next;

    // magnitude of the dividend
    assign dividend_mag = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend)
                                                : SUM_W'(req.dividend);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, work_reg[SUM_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign ge        = trial >= {1'b0, divisor_reg};
    assign rem_next  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    assign work_next = {work_reg[SUM_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            cnt_reg     <= '0;
            work_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            // done pulses for one cycle after the last quotient bit
            done_reg <= busy_reg && !req.start && (cnt_reg == SUM_CNT_W'(1));
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                neg_reg     <= req.dividend[SUM_W-1];
                cnt_reg     <= SUM_CNT_W'(SUM_W);
                work_reg    <= dividend_mag;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == SUM_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quot_mag = work_reg;
    assign rsp.quot_neg = neg_reg;

endmodule

// File: rtl/jpdva_back.sv
// back end: velocity history, running sums, average, pd terms, saturation,
// configuration registers and the result register; depends on jpdva_pkg, jpdva_div
module jpdva_back
    import jpdva_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // queue side
    input  logic                 q_empty,
    input  in_item_t             q_data,
    output logic                 q_pop,
    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_MULP,
        ST_MULD,
        ST_ADD,
        ST_SAT
    } state_t;

    state_t                   state_reg;
    in_item_t                 item_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [RING_W-1:0]        ring_reg;
    logic [SLOTS-1:0]         vbit_reg;
    logic signed [SUM_W-1:0]  sums_reg [JOINTS];
    logic signed [DATA_W-1:0] hist_mem [SLOTS];
    logic signed [DATA_W-1:0] hist_rd_reg;
    logic [DATA_W-1:0]        prop_gain_reg;
    logic [DATA_W-1:0]        deriv_gain_reg;
    logic [FL_W-1:0]          fl_reg;
    logic [DATA_W-1:0]        err_mag_reg;
    logic                     err_neg_reg;
    logic [DATA_W-1:0]        avg_mag_reg;
    logic                     avg_neg_reg;
    logic [PROD_W-1:0]        pmag_reg;
    logic [PROD_W-1:0]        dmag_reg;
    logic [TOT_W-1:0]         tot_reg;
    logic                     out_valid_reg;
    out_item_t                out_reg;

    logic [LEN_W-1:0]         len;
    logic [RING_W-1:0]        ring_use;
    logic [RING_W-1:0]        ring_inc;
    logic signed [DATA_W-1:0] old_vel;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DATA_W:0]   err;
    logic [DATA_W:0]          err_abs;
    logic [TOT_W-1:0]         p_term;
    logic [TOT_W-1:0]         d_term;
    logic [TOT_W-FRAC_W-1:0]  shifted;
    logic [TOT_W-FRAC_W-DATA_W:0] hi_bits;
    logic                     clip;
    logic [DATA_W-1:0]        torque_val;
    logic                     out_free;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign len = eff_len(fl_reg);

    // ring position as used, and its successor modulo the filter length
    assign ring_use = (LEN_W'(ring_reg) >= len) ? '0 : ring_reg;
    assign ring_inc = (LEN_W'(ring_reg) + LEN_W'(1) >= len) ? '0 : ring_reg + 1'b1;

    // running sum update with the sample leaving the window
    assign old_vel  = vbit_reg[slot_reg] ? hist_rd_reg : '0;
    assign sum_next = sums_reg[item_reg.joint_index] - SUM_W'(old_vel)
                      + SUM_W'(item_reg.measured_velocity);

    // position error and its magnitude
    assign err     = (DATA_W+1)'(item_reg.desired_position)
                     - (DATA_W+1)'(item_reg.measured_position);
    assign err_abs = err[DATA_W] ? (DATA_W+1)'(-err) : (DATA_W+1)'(err);

    // signed terms: derivative acts against the averaged velocity
    assign p_term = err_neg_reg ? -TOT_W'(pmag_reg) : TOT_W'(pmag_reg);
    assign d_term = avg_neg_reg ? TOT_W'(dmag_reg) : -TOT_W'(dmag_reg);

    // drop the fraction rounding down, then clip to the signed result range
    assign shifted    = tot_reg[TOT_W-1:FRAC_W];
    assign hi_bits    = shifted[TOT_W-FRAC_W-1:DATA_W-1];
    assign clip       = !((&hi_bits) || !(|hi_bits));
    assign torque_val = clip ? (tot_reg[TOT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                 : {1'b0, {(DATA_W-1){1'b1}}})
                             : shifted[DATA_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // divider hookup
    assign div_req.start    = state_reg == ST_SUM;
    assign div_req.dividend = sum_next;
    assign div_req.divisor  = len;

    jpdva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            slot_reg       <= '0;
            ring_reg       <= '0;
            vbit_reg       <= '0;
            for (int j = 0; j < JOINTS; j++)
                sums_reg[j] <= '0;
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            fl_reg         <= FL_RST;
            err_mag_reg    <= '0;
            err_neg_reg    <= 1'b0;
            avg_mag_reg    <= '0;
            avg_neg_reg    <= 1'b0;
            pmag_reg       <= '0;
            dmag_reg       <= '0;
            tot_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            // configuration writes, to be made only while idle; the block itself does not enforce this
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    CFG_FILTER_LENGTH:
                    begin
                        fl_reg   <= cfg_data[FL_W-1:0];
                        vbit_reg <= '0;
                        ring_reg <= '0;
                        for (int j = 0; j < JOINTS; j++)
                            sums_reg[j] <= '0;
                    end
                    default: ;
                endcase
            end

            // result taken downstream, unless the last state loads a new one
            if (out_valid_reg && !out_stall && (state_reg != ST_SAT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_reg  <= q_data;
                        ring_reg  <= ring_use;
                        slot_reg  <= SLOT_W'(ring_use) * SLOT_W'(JOINTS)
                                     + SLOT_W'(q_data.joint_index);
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sums_reg[item_reg.joint_index] <= sum_next;
                    vbit_reg[slot_reg]             <= 1'b1;
                    err_mag_reg                    <= err_abs[DATA_W-1:0];
                    err_neg_reg                    <= err[DATA_W];
                    state_reg                      <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        avg_mag_reg <= div_rsp.quot_mag[DATA_W-1:0];
                        avg_neg_reg <= div_rsp.quot_neg;
                        state_reg   <= ST_MULP;
                    end
                end
                ST_MULP:
                begin
                    pmag_reg  <= prop_gain_reg * err_mag_reg;
                    state_reg <= ST_MULD;
                end
                ST_MULD:
                begin
                    dmag_reg  <= deriv_gain_reg * avg_mag_reg;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    tot_reg   <= p_term + d_term;
                    state_reg <= ST_SAT;
                end
                ST_SAT:
                begin
                    if (out_free)
                    begin
                        out_reg.joint_out <= item_reg.joint_index;
                        out_reg.torque    <= torque_val;
                        out_reg.saturated <= clip;
                        out_valid_reg     <= 1'b1;
                        if (int'(item_reg.joint_index) == JOINTS - 1)
                            ring_reg <= ring_inc;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // velocity history memory, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            hist_rd_reg <= hist_mem[slot_reg];
        if (state_reg == ST_SUM)
            hist_mem[slot_reg] <= item_reg.measured_velocity;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/joint_pd_with_velocity_average_top.sv
// top level of the joint pd controller with moving-average velocity
// depends on jpdva_pkg, jpdva_front, jpdva_fifo, jpdva_back
//
//  channel  handshake            payload
//  in       in_valid / in_stall  in_data   (in_item_t: joint, positions, velocity)
//  out      out_valid / out_stall out_data (out_item_t: joint, torque, saturated)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data (gains, filter length)
//
// in the back end the bit-serial divider forms the average, one quotient bit
// a cycle over the sum width. items for joints that do not exist are taken
// and dropped without a result. reset clears the history valid bits, sums and
// ring position at once; a filter length write does the same. the queue keeps
// taking items while it has room and the back end works, and a result waits
// in the output register under out_stall.
module joint_pd_with_velocity_average_top
    import jpdva_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic     q_full, q_empty, q_push, q_pop;
    in_item_t q_push_data, q_pop_data;

    // registers are always writable
    assign cfg_ready = 1'b1;

    jpdva_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    jpdva_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    jpdva_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the joint pd controller with moving-average velocity
// depends on jpdva_pkg and joint_pd_with_velocity_average_top
module testbench
    import jpdva_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);
    localparam logic [JOINT_W-1:0]   NO_SUCH_JOINT  = JOINT_W'(JOINTS);
    localparam int                   SETTLE_CYCLES  = 160;
    localparam logic signed [99:0]   TORQUE_MAX     = 100'sd2147483647;
    localparam logic signed [99:0]   TORQUE_MIN     = -100'sd2147483648;

    // block ports, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    // controller state as the testbench sees it
    logic [31:0] prop_gain_q;
    logic [31:0] deriv_gain_q;
    logic [3:0]  filt_len_q;
    longint      vel_ring [FILTER_DEPTH*JOINTS];
    longint      vel_sums [JOINTS];
    int          ring_pos;

    out_item_t   pending_torques [$];
    out_item_t   oldest_torque;
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_cycles    = 0;

    joint_pd_with_velocity_average_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // clear velocity history, sums and ring position
    task automatic clear_history();
        foreach (vel_ring[i])
            vel_ring[i] = 0;
        foreach (vel_sums[i])
            vel_sums[i] = 0;
        ring_pos = 0;
    endtask

    // work out the torque for one accepted item and queue it; items for missing joints are skipped
    task automatic predict_sample(input in_item_t s);
        int                 len;
        int                 slot;
        int                 j;
        longint             avg;
        longint             err;
        logic signed [99:0] pg;
        logic signed [99:0] dg;
        logic signed [99:0] e;
        logic signed [99:0] a;
        logic signed [99:0] v;
        logic signed [99:0] t;
        out_item_t          r;
        j = int'(s.joint_index);
        if (j >= JOINTS)
            return;
        // zero reads as one, anything past the history depth is clamped
        if (filt_len_q == 4'd0)
            len = 1;
        else if (int'(filt_len_q) > FILTER_DEPTH)
            len = FILTER_DEPTH;
        else
            len = int'(filt_len_q);
        if (ring_pos >= len)
            ring_pos = 0;
        slot = ring_pos * JOINTS + j;
        vel_sums[j] = vel_sums[j] - vel_ring[slot] + longint'(s.measured_velocity);
        vel_ring[slot] = longint'(s.measured_velocity);
        avg = vel_sums[j] / longint'(len);
        err = longint'(s.desired_position) - longint'(s.measured_position);
        // exact Q32.32 value, floored back to Q16.16
        pg = {68'd0, prop_gain_q};
        dg = {68'd0, deriv_gain_q};
        e  = err;
        a  = avg;
        v  = pg * e - dg * a;
        t  = v >>> 16;
        r.joint_out = s.joint_index;
        if (t > TORQUE_MAX)
        begin
            r.torque    = 32'h7FFF_FFFF;
            r.saturated = 1'b1;
        end
        else if (t < TORQUE_MIN)
        begin
            r.torque    = 32'h8000_0000;
            r.saturated = 1'b1;
        end
        else
        begin
            r.torque    = t[31:0];
            r.saturated = 1'b0;
        end
        if (j == JOINTS - 1)
            ring_pos = (ring_pos + 1) % len;
        pending_torques.insert(pending_torques.size(), r);
    endtask

    // offer one item, idling at random first, and wait for it to be taken
    task automatic send_sample(input in_item_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sample(s);
    endtask

    task automatic send_fields(input int j, input logic [31:0] d, input logic [31:0] m,
                               input logic [31:0] v);
        in_item_t s;
        s.joint_index       = JOINT_W'(j);
        s.desired_position  = d;
        s.measured_position = m;
        s.measured_velocity = v;
        send_sample(s);
    endtask

    // sender holds off until every torque is back and the back end has gone quiet
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_torques.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // one register write; only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PROP_GAIN:
                prop_gain_q = val;
            CFG_DERIV_GAIN:
                deriv_gain_q = val;
            CFG_FILTER_LENGTH:
            begin
                filt_len_q = val[3:0];
                clear_history();
            end
            default:
                ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // gains and filter length in one go; upper data bits of the length are junk
    task automatic configure(input logic [31:0] p, input logic [31:0] d, input logic [3:0] fl);
        wait_drain();
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_FILTER_LENGTH, {28'($urandom), fl});
    endtask

    // mostly modest Q16.16 values with the extremes and full-range words mixed in
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(32'h001F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    // receiver: random stall, or a long hold-off when asked for
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // compare each torque taken with the oldest one expected
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_torques.size() == 0)
                report_mismatch("unexpected item", {29'd0, out_data.joint_out},
                                out_data.torque);
            else
            begin
                oldest_torque = pending_torques.pop_front();
                if (out_data.joint_out !== oldest_torque.joint_out)
                    report_mismatch("joint_out", {29'd0, out_data.joint_out},
                                    {29'd0, oldest_torque.joint_out});
                if (out_data.torque !== oldest_torque.torque)
                    report_mismatch("torque", out_data.torque, oldest_torque.torque);
                if (out_data.saturated !== oldest_torque.saturated)
                    report_mismatch("saturated", {31'd0, out_data.saturated},
                                    {31'd0, oldest_torque.saturated});
            end
        end
    end

    // field extremes, the missing joint, rounding and saturation at reset gains
    task automatic test_directed_samples();
        send_fields(0, 32'h0, 32'h0, 32'h0);
        send_fields(6, 32'h0001_0000, 32'h0, 32'h0);
        send_fields(NO_SUCH_JOINT, $urandom, $urandom, $urandom);
        send_fields(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_fields(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_fields(1, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_fields(1, 32'h0, 32'h0, 32'h8000_0000);
        send_fields(2, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
        send_fields(4, 32'h5, 32'h3, 32'hFFFF_FFFF);
        send_fields(5, 32'h1234_5678, 32'h1234_5678, 32'h8000_0000);
        send_fields(6, 32'h0, 32'h0, 32'h7FFF_FFFF);
    endtask

    // gain extremes, zero and oversized filter lengths, the unused register index
    task automatic test_register_extremes();
        configure(32'hFFFF_FFFF, 32'h0, 4'd0);
        send_fields(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_fields(0, 32'h0000_0001, 32'h0, 32'h0);
        send_fields(0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        configure(32'h0, 32'hFFFF_FFFF, 4'd9);
        send_fields(2, 32'h0, 32'h0, 32'h7FFF_FFFF);
        send_fields(2, 32'h0, 32'h0, 32'h8000_0000);
        send_fields(2, 32'h0, 32'h0, 32'h0000_0001);
        configure(32'h0001_8001, 32'h0000_0001, 4'd15);
        write_reg(CFG_UNUSED_IDX, $urandom);
        send_fields(6, 32'h0003_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_fields(6, 32'h8000_0000, 32'h0, 32'h8000_0000);
        configure(32'h0000_0001, 32'h0000_0001, 4'd8);
        send_fields(5, 32'h0, 32'h0000_0001, 32'h7FFF_FFFF);
    endtask

    // mostly full sweeps over the joints so the ring turns over, some lone items
    task automatic test_random_traffic(input int n_items);
        int sent;
        int j;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                for (j = 0; j < JOINTS; j++)
                    send_fields(j, rand_q16(), rand_q16(), rand_q16());
                sent += JOINTS;
            end
            else
            begin
                j = $urandom_range(JOINTS);
                send_fields(j, rand_q16(), rand_q16(), rand_q16());
                if (j < JOINTS)
                    sent++;
            end
        end
    endtask

    // receiver holds off long enough for the input to stall, sender keeps offering
    task automatic test_backpressure();
        int j;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        for (j = 0; j < 28; j++)
            send_fields(j % JOINTS, rand_q16(), rand_q16(), rand_q16());
        wait_drain();
    endtask

    initial
    begin
        prop_gain_q  = PROP_GAIN_RST;
        deriv_gain_q = DERIV_GAIN_RST;
        filt_len_q   = FL_RST;
        clear_history();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 81;
        test_directed_samples();
        test_register_extremes();
        configure($urandom_range(32'h00FF_FFFF), $urandom_range(32'h00FF_FFFF), 4'd1);
        test_random_traffic(140);
        configure(PROP_GAIN_RST, DERIV_GAIN_RST, 4'd4);
        test_random_traffic(140);

        wait_drain();
        send_idle_pct = 81;
        recv_idle_pct = 38;
        configure($urandom, $urandom, 4'd8);
        test_random_traffic(140);
        configure($urandom_range(32'h003F_FFFF), $urandom_range(32'h000F_FFFF), 4'd2);
        test_random_traffic(140);

        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure($urandom_range(32'h000F_FFFF), $urandom_range(32'h00FF_FFFF), 4'd12);
        test_random_traffic(140);
        test_backpressure();

        wait_drain();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
